// File: rtl/irph_pkg.sv
// Shared types, constants and helper functions for the IR pulse pattern hasher.
// No dependencies; imported by ir_pulse_pattern_hasher.
package irph_pkg;

	localparam int MAX_EDGES   = 512;
	localparam int EDGE_CNT_W  = $clog2(MAX_EDGES);
	localparam int GAP_W       = 16;
	localparam int TS_W        = 32;
	localparam int HASH_W      = 32;

	localparam logic [EDGE_CNT_W-1:0] EDGE_LIMIT     = EDGE_CNT_W'(MAX_EDGES - 1);
	localparam logic [EDGE_CNT_W-1:0] MIN_CODE_EDGES = EDGE_CNT_W'(6);
	localparam logic [EDGE_CNT_W-1:0] RATIO_START    = EDGE_CNT_W'(2);

	localparam logic [HASH_W-1:0] FNV_PRIME = 32'd16777619;
	localparam logic [HASH_W-1:0] FNV_BASIS = 32'd2166136261;

	localparam logic [GAP_W-1:0] MIN_GAP_RESET = 16'd3000;
	localparam logic [GAP_W-1:0] END_GAP_RESET = 16'd3000;

	// line event codes
	localparam logic [1:0] EV_FALL = 2'd0;
	localparam logic [1:0] EV_RISE = 2'd1;

	// configuration register indexes
	localparam logic CFG_MIN_GAP = 1'b0;
	localparam logic CFG_END_GAP = 1'b1;

	// ratio symbols folded into the hash
	localparam logic [2:0] RATIO_SHORTER = 3'd1;
	localparam logic [2:0] RATIO_LONGER  = 3'd2;
	localparam logic [2:0] RATIO_SAME    = 3'd4;

	typedef struct packed {
		logic                  in_code;
		logic [EDGE_CNT_W-1:0] edge_count;
		logic [GAP_W-1:0]      prev1;
		logic [GAP_W-1:0]      prev2;
		logic [HASH_W-1:0]     hash;
	} dec_state_t;

	// 3/4 ratio test between an interval and the one two before it
	function automatic logic [2:0] ratio_code(input logic [GAP_W-1:0] older,
			input logic [GAP_W-1:0] newer);
		logic [GAP_W+1:0] new4;
		logic [GAP_W+1:0] old4;
		logic [GAP_W+1:0] new3;
		logic [GAP_W+1:0] old3;
		new4 = {newer, 2'b00};
		old4 = {older, 2'b00};
		new3 = {2'b00, newer} + {1'b0, newer, 1'b0};
		old3 = {2'b00, older} + {1'b0, older, 1'b0};
		if (new4 < old3)
			return RATIO_SHORTER;
		else if (old4 < new3)
			return RATIO_LONGER;
		else
			return RATIO_SAME;
	endfunction

	// one FNV-1a round: xor the symbol, multiply by the prime modulo 2^32
	function automatic logic [HASH_W-1:0] fnv_step(input logic [HASH_W-1:0] h,
			input logic [2:0] sym);
		logic [HASH_W-1:0] hx;
		hx = h ^ {{(HASH_W-3){1'b0}}, sym};
		return hx * FNV_PRIME;
	endfunction

endpackage

// File: rtl/ir_pulse_pattern_hasher.sv
// IR pulse pattern hasher: input register, dual-polarity decoders, result register.
// Depends on irph_pkg.
//
// Takes one line event per clock and gives the FNV-1a hash of each completed IR
// code. Every event is captured in an input register; when it moves on, the
// interval since the last level change is formed, both decoders (active-high and
// active-low) advance, and a finished code is loaded into the result register.
// Sustained rate is one event per cycle, set by the decoder state loop (interval
// subtract, gap compares, ratio test and the xor-multiply hash round). The input
// stalls only while a result waits in the output register and an event is
// already held in the input register.
module ir_pulse_pattern_hasher
	import irph_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [GAP_W-1:0]  cfg_data,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [1:0]        line_event,
	input  logic [TS_W-1:0]   timestamp_us,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [HASH_W-1:0] code_hash,
	output logic              polarity
);

	logic [GAP_W-1:0]  min_gap_q;
	logic [GAP_W-1:0]  end_gap_q;

	logic              valid_s1;
	logic [1:0]        event_s1;
	logic [TS_W-1:0]   ts_s1;

	logic              started_q;
	logic [TS_W-1:0]   last_edge_q;
	dec_state_t        dec_q [2];
	dec_state_t        dec_d [2];
	logic [1:0]        got;

	logic              out_valid_q;
	logic [HASH_W-1:0] hash_q;
	logic              polarity_q;

	logic              proceed;
	logic              step;
	logic              is_change;
	logic [TS_W-1:0]   interval;
	logic [GAP_W-1:0]  iv16;
	logic              res_valid;
	logic [HASH_W-1:0] res_hash;
	logic              res_pol;

	assign proceed   = !out_valid_q || !out_stall;
	assign in_stall  = valid_s1 && !proceed;
	assign step      = valid_s1 && proceed && started_q;
	assign is_change = !event_s1[1];
	assign interval  = ts_s1 - last_edge_q;
	assign iv16      = interval[GAP_W-1:0];

	assign out_valid = out_valid_q;
	assign code_hash = hash_q;
	assign polarity  = polarity_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_gap_q <= MIN_GAP_RESET;
			end_gap_q <= END_GAP_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_MIN_GAP: min_gap_q <= cfg_data;
				CFG_END_GAP: end_gap_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			event_s1 <= line_event;
			ts_s1    <= timestamp_us;
		end
	end

	// decoder next state; the two decoders are independent
	always_comb begin
		for (int d = 0; d < 2; d++) begin
			dec_d[d] = dec_q[d];
			got[d]   = 1'b0;
			if (step) begin
				if (!dec_q[d].in_code) begin
					if (event_s1 == ((d == 0) ? EV_FALL : EV_RISE) &&
							interval > {{(TS_W-GAP_W){1'b0}}, min_gap_q}) begin
						dec_d[d].in_code    = 1'b1;
						dec_d[d].edge_count = '0;
						dec_d[d].prev1      = '0;
						dec_d[d].prev2      = '0;
						dec_d[d].hash       = FNV_BASIS;
					end
				end else if (interval > {{(TS_W-GAP_W){1'b0}}, end_gap_q}) begin
					dec_d[d].in_code = 1'b0;
					got[d] = dec_q[d].edge_count >= MIN_CODE_EDGES && dec_q[d].hash != '0;
				end else if (is_change && dec_q[d].edge_count < EDGE_LIMIT) begin
					if (dec_q[d].edge_count >= RATIO_START)
						dec_d[d].hash = fnv_step(dec_q[d].hash,
							ratio_code(dec_q[d].prev2, iv16));
					dec_d[d].prev2      = dec_q[d].prev1;
					dec_d[d].prev1      = iv16;
					dec_d[d].edge_count = dec_q[d].edge_count + EDGE_CNT_W'(1);
				end
			end
		end
		// active-high decoder takes priority
		res_valid = got[0] || got[1];
		res_pol   = !got[0];
		res_hash  = got[0] ? dec_q[0].hash : dec_q[1].hash;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q   <= 1'b0;
			last_edge_q <= '0;
			for (int d = 0; d < 2; d++) begin
				dec_q[d].in_code    <= 1'b0;
				dec_q[d].edge_count <= '0;
				dec_q[d].prev1      <= '0;
				dec_q[d].prev2      <= '0;
				dec_q[d].hash       <= FNV_BASIS;
			end
		end else if (valid_s1 && proceed) begin
			// first event only seeds the timestamp
			started_q <= 1'b1;
			if (!started_q || is_change)
				last_edge_q <= ts_s1;
			dec_q[0] <= dec_d[0];
			dec_q[1] <= dec_d[1];
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (proceed) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (proceed && res_valid) begin
			hash_q     <= res_hash;
			polarity_q <= res_pol;
		end
	end

	a_hash_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> hash_q != '0)
		else $error("result hash is zero");

	a_idle_before_start: assert property (@(posedge clk) disable iff (!arst_n)
		!started_q |-> !dec_q[0].in_code && !dec_q[1].in_code)
		else $error("decoder in code before first event");

	a_result_from_event: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(valid_s1) && $past(started_q))
		else $error("result without a processed event");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && out_valid_q && out_stall)
		else $error("input stalled without a blocked result");

endmodule

// File: test/ir_pulse_pattern_hasher_tb.sv
// Self-checking testbench for ir_pulse_pattern_hasher: drives IR line events, predicts
// the code hashes of both decoders and compares every result transfer in order.
// Depends on irph_pkg and the ir_pulse_pattern_hasher RTL.
module ir_pulse_pattern_hasher_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import irph_pkg::*;

	localparam logic [1:0]  EV_TIMEOUT     = 2'd2;
	localparam logic [1:0]  EV_TIMEOUT_ALT = 2'd3;
	localparam logic [31:0] HASH_SEED      = 32'd2166136261;
	localparam logic [31:0] HASH_MULT      = 32'd16777619;
	localparam logic [8:0]  EDGE_CAP       = 9'(MAX_EDGES - 1);
	localparam logic [8:0]  CODE_MIN_EDGES = 9'd6;
	localparam int          HOLD_CYCLES    = 200;
	localparam int          RUN_LIMIT      = 500000;

	typedef struct packed {
		logic [31:0] hash;
		logic        pol;
	} code_rec_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_we = 1'b0;
	logic              cfg_index = CFG_MIN_GAP;
	logic [GAP_W-1:0]  cfg_data = '0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic [1:0]        line_event = EV_FALL;
	logic [TS_W-1:0]   timestamp_us = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [HASH_W-1:0] code_hash;
	logic              polarity;

	// predictor state
	logic [15:0] gap_min_cfg;
	logic [15:0] gap_end_cfg;
	logic        seen_first;
	logic [31:0] last_change_ts;
	logic        dec_active [2];
	logic [8:0]  dec_edges [2];
	logic [15:0] dec_iv1 [2];
	logic [15:0] dec_iv2 [2];
	logic [31:0] dec_hash [2];
	code_rec_t   pending_codes [$];

	// stimulus state
	logic [15:0] cur_min = MIN_GAP_RESET;
	logic [15:0] cur_end = END_GAP_RESET;
	logic [31:0] now_ts = '0;
	logic        line_lvl = 1'b0;
	logic        tx_idle_on = 1'b1;
	logic        rx_idle_on = 1'b1;
	logic        rx_hold = 1'b0;
	int          xfer_cnt = 0;
	int          mismatch_cnt = 0;
	int          cycle_cnt = 0;

	ir_pulse_pattern_hasher u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.line_event   (line_event),
		.timestamp_us (timestamp_us),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.code_hash    (code_hash),
		.polarity     (polarity)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == RUN_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	function automatic void clear_model();
		gap_min_cfg = MIN_GAP_RESET;
		gap_end_cfg = END_GAP_RESET;
		seen_first = 1'b0;
		last_change_ts = '0;
		for (int i = 0; i < 2; i++) begin
			dec_active[i] = 1'b0;
			dec_edges[i] = '0;
			dec_iv1[i] = '0;
			dec_iv2[i] = '0;
			dec_hash[i] = HASH_SEED;
		end
	endfunction

	// advance both decoders by one line event and queue the code it completes, if any
	function automatic void predict_event(input logic [1:0] ev, input logic [31:0] ts);
		logic [31:0] span;
		logic        is_change;
		logic [1:0]  done;
		logic [31:0] fin_hash [2];
		logic [15:0] iv;
		logic [2:0]  sym;
		logic [1:0]  idle_ev;
		int          d;
		if (!seen_first) begin
			seen_first = 1'b1;
			last_change_ts = ts;
			return;
		end
		span = ts - last_change_ts;
		is_change = (ev == EV_FALL) || (ev == EV_RISE);
		if (is_change)
			last_change_ts = ts;
		done = '0;
		for (d = 0; d < 2; d++) begin
			idle_ev = (d == 0) ? EV_FALL : EV_RISE;
			fin_hash[d] = '0;
			if (!dec_active[d]) begin
				if (ev == idle_ev && span > {16'd0, gap_min_cfg}) begin
					dec_active[d] = 1'b1;
					dec_edges[d] = '0;
					dec_iv1[d] = '0;
					dec_iv2[d] = '0;
					dec_hash[d] = HASH_SEED;
				end
			end else if (span > {16'd0, gap_end_cfg}) begin
				dec_active[d] = 1'b0;
				if (dec_edges[d] >= CODE_MIN_EDGES && dec_hash[d] != '0) begin
					done[d] = 1'b1;
					fin_hash[d] = dec_hash[d];
				end
			end else if (is_change && dec_edges[d] < EDGE_CAP) begin
				iv = span[15:0];
				if (dec_edges[d] >= 9'd2) begin
					if (4 * int'(iv) < 3 * int'(dec_iv2[d]))
						sym = RATIO_SHORTER;
					else if (4 * int'(dec_iv2[d]) < 3 * int'(iv))
						sym = RATIO_LONGER;
					else
						sym = RATIO_SAME;
					dec_hash[d] = (dec_hash[d] ^ {29'd0, sym}) * HASH_MULT;
				end
				dec_iv2[d] = dec_iv1[d];
				dec_iv1[d] = iv;
				dec_edges[d] = dec_edges[d] + 9'd1;
			end
		end
		// active-high decoder wins a tie
		if (done[0])
			pending_codes.push_back('{hash: fin_hash[0], pol: 1'b0});
		else if (done[1])
			pending_codes.push_back('{hash: fin_hash[1], pol: 1'b1});
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_we) begin
				if (cfg_index == CFG_MIN_GAP)
					gap_min_cfg = cfg_data;
				else
					gap_end_cfg = cfg_data;
			end
			if (in_valid && !in_stall)
				predict_event(line_event, timestamp_us);
		end
	end

	always @(posedge clk) begin : check_codes
		code_rec_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_codes.size() == 0) begin
				mismatch_cnt++;
				if (mismatch_cnt <= 10)
					$display("unexpected code: hash %h polarity %0d", code_hash, polarity);
			end else begin
				want = pending_codes.pop_front();
				if (code_hash !== want.hash || polarity !== want.pol) begin
					mismatch_cnt++;
					if (mismatch_cnt <= 10)
						$display("code mismatch: expected hash %h polarity %0d, got hash %h polarity %0d",
							want.hash, want.pol, code_hash, polarity);
				end
			end
		end
	end

	// result side: random stall bursts, or one long hold on request
	initial begin
		forever begin
			@(posedge clk);
			if (rx_hold) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				out_stall <= 1'b0;
				rx_hold = 1'b0;
			end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 9)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	task automatic send_event(input logic [1:0] ev, input logic [31:0] ts);
		if (tx_idle_on && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		in_valid <= 1'b1;
		line_event <= ev;
		timestamp_us <= ts;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		xfer_cnt++;
	endtask

	task automatic send_delta(input logic [1:0] ev, input logic [31:0] dt);
		now_ts = now_ts + dt;
		if (ev == EV_FALL || ev == EV_RISE)
			line_lvl = ev[0];
		send_event(ev, now_ts);
	endtask

	task automatic toggle(input logic [31:0] dt);
		send_delta(line_lvl ? EV_FALL : EV_RISE, dt);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		// let the predictor queue the last transfer first
		@(posedge clk);
		while (pending_codes.size() != 0)
			@(posedge clk);
		// events that give no code may still be in flight
		repeat (6) @(posedge clk);
	endtask

	task automatic set_gaps(input logic [15:0] min_us, input logic [15:0] end_us);
		cur_min = min_us;
		cur_end = end_us;
		cfg_we <= 1'b1;
		cfg_index <= CFG_MIN_GAP;
		cfg_data <= min_us;
		@(posedge clk);
		cfg_index <= CFG_END_GAP;
		cfg_data <= end_us;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [31:0] pick_interval(input logic [31:0] unit);
		logic [31:0] iv;
		case ($urandom_range(0, 4))
			0: iv = unit;
			1: iv = unit * 2;
			2: iv = unit * 3 / 4;
			3: iv = $urandom_range(0, cur_end);
			default: iv = unit + $urandom_range(0, 15);
		endcase
		return (iv > {16'd0, cur_end}) ? {16'd0, cur_end} : iv;
	endfunction

	// leading gap on the idle level, a pulse train, then an ending gap
	task automatic send_code(input logic pol, input int n_iv);
		logic [31:0] unit;
		logic [31:0] stop_dt;
		unit = $urandom_range(cur_end / 8, cur_end / 2);
		send_delta(pol ? EV_RISE : EV_FALL, {16'd0, cur_min} + 32'd1 + $urandom_range(0, 3000));
		repeat (n_iv)
			toggle(pick_interval(unit));
		stop_dt = {16'd0, cur_end} + 32'd1 + $urandom_range(0, 5000);
		case ($urandom_range(0, 2))
			0: toggle(stop_dt);
			1: send_delta(EV_TIMEOUT, stop_dt);
			default: send_delta(EV_TIMEOUT_ALT, stop_dt);
		endcase
	endtask

	task automatic send_noise();
		logic [1:0] ev;
		ev = 2'($urandom_range(0, 3));
		if ($urandom_range(0, 2) == 0) begin
			now_ts = $urandom();
			send_delta(ev, 32'd0);
		end else begin
			send_delta(ev, $urandom_range(0, 2 * cur_end + 2));
		end
	endtask

	task automatic run_random(input int n_items);
		int target;
		target = xfer_cnt + n_items;
		while (xfer_cnt < target) begin
			if ($urandom_range(0, 9) < 7) begin
				send_code(1'($urandom_range(0, 1)),
					($urandom_range(0, 7) == 0) ? $urandom_range(0, 40) : $urandom_range(4, 16));
			end else begin
				repeat ($urandom_range(1, 4))
					send_noise();
			end
		end
		drain();
	endtask

	task automatic test_directed();
		send_delta(EV_RISE, 32'd0);
		// active-high code: boundary gaps, all three ratio symbols, the exact 3/4 tie
		send_delta(EV_FALL, 32'd3001);
		toggle(32'd560);
		toggle(32'd560);
		toggle(32'd1690);
		toggle(32'd560);
		toggle(32'd400);
		toggle(32'd3000);
		toggle(32'd300);
		toggle(32'd0);
		send_delta(EV_TIMEOUT, 32'd3001);
		// active-low code across the timestamp wrap, ended by event code 3
		now_ts = 32'hFFFF_F000;
		send_delta(EV_RISE, 32'd0);
		repeat (6)
			toggle(32'd700);
		send_delta(EV_TIMEOUT_ALT, 32'd65535);
		// five intervals only: dropped; a short timeout inside changes nothing
		send_delta(EV_FALL, 32'd4000);
		toggle(32'd500);
		toggle(32'd500);
		send_delta(EV_TIMEOUT, 32'd200);
		toggle(32'd500);
		toggle(32'd500);
		toggle(32'd500);
		send_delta(EV_TIMEOUT, 32'd3500);
		send_delta(EV_TIMEOUT, 32'hFFFF_FFFF);
		drain();
	endtask

	task automatic test_both_polarities();
		set_gaps(16'd1000, 16'd3000);
		send_delta(EV_TIMEOUT, 32'd70000);
		// both decoders finish together, both qualify
		send_delta(EV_RISE, 32'd5000);
		send_delta(EV_FALL, 32'd2000);
		repeat (8)
			toggle($urandom_range(400, 900));
		send_delta(EV_TIMEOUT, 32'd4000);
		// both finish together, only the active-low one qualifies
		send_delta(EV_RISE, 32'd5000);
		repeat (4)
			toggle(32'd600);
		send_delta(EV_FALL, 32'd2000);
		repeat (3)
			toggle(32'd700);
		send_delta(EV_TIMEOUT, 32'd4000);
		drain();
	endtask

	task automatic test_saturation();
		set_gaps(MIN_GAP_RESET, END_GAP_RESET);
		send_code(1'b0, MAX_EDGES + 12);
		drain();
	endtask

	task automatic test_gap_settings();
		set_gaps(16'd0, 16'd0);
		run_random(150);
		set_gaps(16'hFFFF, 16'hFFFF);
		run_random(150);
		set_gaps(16'd500, 16'd200);
		run_random(150);
		set_gaps(16'd1000, 16'd5000);
		run_random(150);
		set_gaps(16'($urandom()), 16'($urandom()));
		run_random(150);
		set_gaps(MIN_GAP_RESET, END_GAP_RESET);
		run_random(150);
	endtask

	task automatic test_backpressure();
		tx_idle_on = 1'b0;
		rx_hold = 1'b1;
		repeat (3)
			send_code(1'($urandom_range(0, 1)), 8);
		while (rx_hold)
			@(posedge clk);
		drain();
		tx_idle_on = 1'b1;
	endtask

	task automatic test_steady_stream();
		tx_idle_on = 1'b0;
		rx_idle_on = 1'b0;
		run_random(150);
	endtask

	initial begin
		clear_model();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_both_polarities();
		test_saturation();
		test_gap_settings();
		test_backpressure();
		test_steady_stream();
		if (mismatch_cnt == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
